@@ rtl/core/upc_pkg.sv @@
// shared types, character codes and helper functions of the url percent codec
package upc_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // job queue between classifier and serializer
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCountW = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } esc_phase_t;

    // up to three output bytes caused by one input byte
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       last;
    } upc_job_t;

    // bit 4 set: not an uppercase hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = c - CH_ZERO;
                hex_value = {1'b0, d[3:0]};
            end
            else if (c >= CH_UA && c < CH_UG)
            begin
                d = c - CH_AT + 8'd9;
                hex_value = {1'b0, d[3:0]};
            end
            else
            begin
                hex_value = 5'h10;
            end
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        begin
            if (n < 4'd10)
                hex_char = CH_ZERO + {4'h0, n};
            else
                hex_char = CH_UA + {4'h0, n} - 8'd10;
        end
    endfunction

    function automatic logic is_safe(input logic [7:0] c);
        begin
            is_safe = (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
                      (c >= CH_ZERO && c <= CH_NINE) || c == CH_STAR ||
                      c == CH_DASH || c == CH_DOT || c == CH_UNDER || c == CH_SPACE;
        end
    endfunction

endpackage

@@ rtl/core/upc_if.sv @@
// channel interfaces of the url percent codec: input bytes, output bytes, mode writes
interface upc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface upc_cfg_if;
    logic valid;
    logic ready;
    logic direction_mode;

    modport source (output valid, output direction_mode, input ready);
    modport sink   (input valid, input direction_mode, output ready);
endinterface

@@ rtl/core/upc_front.sv @@
// classifier: accepts bytes, tracks escape state, builds output jobs
module upc_front
    import upc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    upc_in_if.sink       in_ch,
    upc_cfg_if.sink      cfg_ch,
    input  logic         q_full,
    output logic         push,
    output upc_job_t     job
);

    logic       mode_reg;
    esc_phase_t phase_reg;
    esc_phase_t phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;
    logic [4:0] hv_in;
    logic [4:0] hv_held;
    logic       plain_valid;
    logic [7:0] plain_byte;
    esc_phase_t plain_phase;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !q_full;
    assign accept       = in_ch.valid && !q_full;

    // plain-text handling of one decoded byte
    always_comb
    begin
        plain_valid = 1'b1;
        plain_byte  = in_ch.in_byte;
        plain_phase = PH_IDLE;
        if (in_ch.in_byte == CH_PCT)
        begin
            plain_valid = in_ch.in_last;
            plain_phase = in_ch.in_last ? PH_IDLE : PH_PCT;
        end
        else if (in_ch.in_byte == CH_PLUS)
        begin
            plain_byte = CH_SPACE;
        end
    end

    always_comb
    begin
        hv_in      = hex_value(in_ch.in_byte);
        hv_held    = hex_value(held_reg);
        job        = '0;
        job.last   = in_ch.in_last;
        phase_next = phase_reg;
        held_next  = held_reg;
        if (mode_reg == MODE_ENCODE)
        begin
            phase_next = PH_IDLE;
            job.cnt    = 2'd1;
            job.b0     = in_ch.in_byte;
            if (!is_safe(in_ch.in_byte))
            begin
                job.cnt = 2'd3;
                job.b0  = CH_PCT;
                job.b1  = hex_char(in_ch.in_byte[7:4]);
                job.b2  = hex_char(in_ch.in_byte[3:0]);
            end
            else if (in_ch.in_byte == CH_SPACE)
            begin
                job.b0 = CH_PLUS;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_PCT:
                begin
                    if (!hv_in[4])
                    begin
                        if (in_ch.in_last)
                        begin
                            job.cnt    = 2'd1;
                            job.b0     = in_ch.in_byte;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            held_next  = in_ch.in_byte;
                            phase_next = PH_DIGIT;
                        end
                    end
                    else
                    begin
                        job.cnt    = {1'b0, plain_valid};
                        job.b0     = plain_byte;
                        phase_next = plain_phase;
                    end
                end
                PH_DIGIT:
                begin
                    if (!hv_in[4])
                    begin
                        job.cnt    = 2'd1;
                        job.b0     = {hv_held[3:0], hv_in[3:0]};
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        // held digit goes out as text, then the byte as plain text unless it opens a new escape
                        job.cnt    = plain_valid ? 2'd2 : 2'd1;
                        job.b0     = held_reg;
                        job.b1     = plain_byte;
                        phase_next = plain_phase;
                    end
                end
                default:
                begin
                    job.cnt    = {1'b0, plain_valid};
                    job.b0     = plain_byte;
                    phase_next = plain_phase;
                end
            endcase
        end
        push = accept && job.cnt != 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENCODE;
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else
        begin
            if (cfg_ch.valid)
                mode_reg <= cfg_ch.direction_mode;
            if (accept)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
        end
    end

    a_encode_clears_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == MODE_ENCODE) |=> phase_reg == PH_IDLE)
        else $error("escape left pending after encode");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job pushed into full queue");

endmodule

@@ rtl/core/upc_queue.sv @@
// short job queue between classifier and serializer
module upc_queue
    import upc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  upc_job_t push_job,
    input  logic     pop,
    output logic     q_valid,
    output logic     q_full,
    output upc_job_t head
);

    upc_job_t            mem_reg [QDepth];
    logic [QPtrW-1:0]    wr_ptr_reg;
    logic [QPtrW-1:0]    rd_ptr_reg;
    logic [QCountW-1:0]  count_reg;
    logic [QCountW-1:0]  count_next;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == QCountW'(QDepth);
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCountW'(1);
        else if (pop && !push)
            count_next = count_reg - QCountW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            count_reg <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != QCountW'(QDepth)) |->
            (QPtrW'(count_reg) == QPtrW'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count out of step with pointers");

endmodule

@@ rtl/core/upc_back.sv @@
// serializer: sends the bytes of each job through a registered output stage
module upc_back
    import upc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  upc_job_t  head,
    output logic      pop,
    upc_out_if.source out_ch
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic       final_byte;
    logic [7:0] sel_byte;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

    assign load       = q_valid && (!out_valid_reg || out_ch.ready);
    assign final_byte = idx_reg == (head.cnt - 2'd1);
    assign pop        = load && final_byte;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = head.b0;
            2'd1:    sel_byte = head.b1;
            default: sel_byte = head.b2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= sel_byte;
            out_last_reg <= final_byte && head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (load)
                idx_reg <= final_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg < head.cnt))
        else $error("byte index beyond job length");

    a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> idx_reg == 2'd0)
        else $error("byte index left set with empty queue");

endmodule

@@ rtl/core/url_percent_codec.sv @@
// top level of the url percent codec: classifier, job queue, serializer
//
//  channel   dir  payload                 transfer when
//  in_ch     in   in_byte[7:0], in_last   in_ch.valid & in_ch.ready
//  out_ch    out  out_byte[7:0], out_last out_ch.valid & out_ch.ready
//  cfg_ch    in   direction_mode          cfg_ch.valid (ready tied high)
//
// one input byte per cycle while the job queue has room; each byte becomes a
//   job of zero to three output bytes
// the serializer sends one output byte per cycle while out_ch is ready, so encode of an
//   unsafe byte holds the output for three output bytes and the four-entry queue absorbs bursts
// an input byte reaches out_ch through the job queue and then the registered output stage
// reset clears mode (encode), escape state, queue and output stage
// output stalls fill the queue; in_ch.ready drops only when the queue is full
module url_percent_codec
    import upc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    upc_in_if.sink    in_ch,
    upc_out_if.source out_ch,
    upc_cfg_if.sink   cfg_ch
);

    // front to queue
    logic     push;
    upc_job_t job;
    // queue to back
    logic     q_valid;
    logic     q_full;
    logic     pop;
    upc_job_t head;

    // classify each input byte and track the escape sequence
    upc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .q_full (q_full),
        .push   (push),
        .job    (job)
    );

    // decouples byte acceptance from multi-byte output
    upc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .head     (head)
    );

    // walk through each job one byte per transfer
    upc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
